FILE: hdl/qta_pkg.sv
package qta_pkg;

   localparam int SIZE_W = 13;
   localparam int COORD_W = 12;
   localparam int CMD_W = 2;
   localparam int STATUS_W = 2;
   localparam int TILES_W = 9;
   localparam int AREA_W = 25;
   localparam int SHIFT_W = 4;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_NO_FREE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MARK_EMPTY = 2'd0,
      MARK_SPLIT = 2'd1,
      MARK_ALLOC = 2'd2
   } mark_type;

   typedef enum logic [1:0] {
      ADDR_TARGET = 2'd0,
      ADDR_WALK   = 2'd1,
      ADDR_CHILD  = 2'd2,
      ADDR_CLEAR  = 2'd3
   } addr_sel_type;

   typedef enum logic [4:0] {
      ST_CLR_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_CLR,
      ST_A_RD,
      ST_A_CHK,
      ST_A_WUP,
      ST_A_WRD,
      ST_A_WCHK,
      ST_A_MARK,
      ST_A_MUP,
      ST_A_MRD,
      ST_A_MCHK,
      ST_F_RD,
      ST_F_CHK,
      ST_F_UP,
      ST_F_CRD,
      ST_F_CCHK,
      ST_F_PRD,
      ST_F_PCHK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic         latch;
      logic         scan_init;
      logic         scan_next;
      logic         walk_init;
      logic         walk_up;
      logic         child_clr;
      logic         child_next;
      logic         clr_init;
      logic         clr_step;
      logic         rd_en;
      addr_sel_type rd_sel;
      logic         wr_en;
      addr_sel_type wr_sel;
      mark_type     wr_mark;
      logic         cnt_inc;
      logic         cnt_dec;
      logic         cnt_clr;
      logic         pend_set;
      status_type   pend_status;
      logic         pend_alloc;
      logic         res_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       size_ok;
      logic       grid_ok;
      mark_type   rd_mark;
      logic       m_last;
      logic       wl_zero;
      logic       child_last;
      logic       clr_last;
      logic       out_free;
   } dp_stat_type;

   function automatic logic [SHIFT_W-1:0] onehot_log2(input logic [SIZE_W-1:0] s);
      logic [SHIFT_W-1:0] r;
      r = '0;
      for (int i = 0; i < SIZE_W; i++) begin
         if (s[i]) begin
            r = SHIFT_W'(i);
         end
      end
      return r;
   endfunction

endpackage

FILE: hdl/qta_ctrl.sv
module qta_ctrl
   import qta_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  dp_stat_type stat,
   output ctl_cmd_type ctl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      ctl.rd_sel = ADDR_TARGET;
      ctl.wr_sel = ADDR_TARGET;
      ctl.wr_mark = MARK_EMPTY;
      ctl.pend_status = STATUS_DONE;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLR_INIT: begin
            ctl.wr_en = 1'b1;
            ctl.wr_sel = ADDR_CLEAR;
            ctl.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.latch = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (stat.cmd)
               CMD_ALLOC: begin
                  if (stat.size_ok) begin
                     ctl.scan_init = 1'b1;
                     state_in = ST_A_RD;
                  end else begin
                     ctl.pend_set = 1'b1;
                     ctl.pend_status = STATUS_INVALID;
                     state_in = ST_RESP;
                  end
               end
               CMD_FREE: begin
                  if (stat.size_ok && stat.grid_ok) begin
                     state_in = ST_F_RD;
                  end else begin
                     ctl.pend_set = 1'b1;
                     ctl.pend_status = STATUS_INVALID;
                     state_in = ST_RESP;
                  end
               end
               CMD_CLEAR: begin
                  ctl.cnt_clr = 1'b1;
                  ctl.clr_init = 1'b1;
                  state_in = ST_CLR;
               end
               default: begin
                  ctl.pend_set = 1'b1;
                  ctl.pend_status = STATUS_INVALID;
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_CLR: begin
            ctl.wr_en = 1'b1;
            ctl.wr_sel = ADDR_CLEAR;
            ctl.clr_step = 1'b1;
            if (stat.clr_last) begin
               ctl.pend_set = 1'b1;
               ctl.pend_status = STATUS_DONE;
               state_in = ST_RESP;
            end
         end
         ST_A_RD: begin
            ctl.rd_en = 1'b1;
            ctl.rd_sel = ADDR_TARGET;
            state_in = ST_A_CHK;
         end
         ST_A_CHK, ST_A_WCHK: begin
            if ((state_ff == ST_A_CHK && stat.rd_mark != MARK_EMPTY) ||
                (state_ff == ST_A_WCHK && stat.rd_mark == MARK_ALLOC)) begin
               if (stat.m_last) begin
                  ctl.pend_set = 1'b1;
                  ctl.pend_status = STATUS_NO_FREE;
                  state_in = ST_RESP;
               end else begin
                  ctl.scan_next = 1'b1;
                  state_in = ST_A_RD;
               end
            end else begin
               if (state_ff == ST_A_CHK) begin
                  ctl.walk_init = 1'b1;
               end
               state_in = ST_A_WUP;
            end
         end
         ST_A_WUP: begin
            if (stat.wl_zero) begin
               state_in = ST_A_MARK;
            end else begin
               ctl.walk_up = 1'b1;
               state_in = ST_A_WRD;
            end
         end
         ST_A_WRD: begin
            ctl.rd_en = 1'b1;
            ctl.rd_sel = ADDR_WALK;
            state_in = ST_A_WCHK;
         end
         ST_A_MARK: begin
            ctl.wr_en = 1'b1;
            ctl.wr_sel = ADDR_TARGET;
            ctl.wr_mark = MARK_ALLOC;
            ctl.walk_init = 1'b1;
            state_in = ST_A_MUP;
         end
         ST_A_MUP: begin
            if (stat.wl_zero) begin
               ctl.cnt_inc = 1'b1;
               ctl.pend_set = 1'b1;
               ctl.pend_status = STATUS_DONE;
               ctl.pend_alloc = 1'b1;
               state_in = ST_RESP;
            end else begin
               ctl.walk_up = 1'b1;
               state_in = ST_A_MRD;
            end
         end
         ST_A_MRD: begin
            ctl.rd_en = 1'b1;
            ctl.rd_sel = ADDR_WALK;
            state_in = ST_A_MCHK;
         end
         ST_A_MCHK: begin
            if (stat.rd_mark == MARK_EMPTY) begin
               ctl.wr_en = 1'b1;
               ctl.wr_sel = ADDR_WALK;
               ctl.wr_mark = MARK_SPLIT;
            end
            state_in = ST_A_MUP;
         end
         ST_F_RD: begin
            ctl.rd_en = 1'b1;
            ctl.rd_sel = ADDR_TARGET;
            state_in = ST_F_CHK;
         end
         ST_F_CHK: begin
            if (stat.rd_mark != MARK_ALLOC) begin
               ctl.pend_set = 1'b1;
               ctl.pend_status = STATUS_INVALID;
               state_in = ST_RESP;
            end else begin
               ctl.wr_en = 1'b1;
               ctl.wr_sel = ADDR_TARGET;
               ctl.wr_mark = MARK_EMPTY;
               ctl.cnt_dec = 1'b1;
               ctl.walk_init = 1'b1;
               state_in = ST_F_UP;
            end
         end
         ST_F_UP: begin
            if (stat.wl_zero) begin
               ctl.pend_set = 1'b1;
               ctl.pend_status = STATUS_DONE;
               state_in = ST_RESP;
            end else begin
               ctl.child_clr = 1'b1;
               state_in = ST_F_CRD;
            end
         end
         ST_F_CRD: begin
            ctl.rd_en = 1'b1;
            ctl.rd_sel = ADDR_CHILD;
            state_in = ST_F_CCHK;
         end
         ST_F_CCHK: begin
            if (stat.rd_mark != MARK_EMPTY) begin
               ctl.pend_set = 1'b1;
               ctl.pend_status = STATUS_DONE;
               state_in = ST_RESP;
            end else if (stat.child_last) begin
               ctl.walk_up = 1'b1;
               state_in = ST_F_PRD;
            end else begin
               ctl.child_next = 1'b1;
               state_in = ST_F_CRD;
            end
         end
         ST_F_PRD: begin
            ctl.rd_en = 1'b1;
            ctl.rd_sel = ADDR_WALK;
            state_in = ST_F_PCHK;
         end
         ST_F_PCHK: begin
            if (stat.rd_mark != MARK_SPLIT) begin
               ctl.pend_set = 1'b1;
               ctl.pend_status = STATUS_DONE;
               state_in = ST_RESP;
            end else begin
               ctl.wr_en = 1'b1;
               ctl.wr_sel = ADDR_WALK;
               ctl.wr_mark = MARK_EMPTY;
               state_in = ST_F_UP;
            end
         end
         ST_RESP: begin
            if (stat.out_free) begin
               ctl.res_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/qta_datapath.sv
module qta_datapath
   import qta_pkg::*;
#(
   parameter int ATLAS_EXTENT = 4096,
   parameter int MIN_TILE = 256
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [SIZE_W-1:0]   req_tile_size,
   input  logic [COORD_W-1:0]  req_tile_x,
   input  logic [COORD_W-1:0]  req_tile_y,
   input  ctl_cmd_type         ctl,
   output dp_stat_type         stat,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COORD_W-1:0]  rsp_out_x,
   output logic [COORD_W-1:0]  rsp_out_y,
   output logic [SIZE_W-1:0]   rsp_out_size,
   output logic [TILES_W-1:0]  rsp_live_tiles,
   output logic [AREA_W-1:0]   rsp_live_area
);

   localparam int LOG_ATLAS = $clog2(ATLAS_EXTENT);
   localparam int LEVELS = LOG_ATLAS - $clog2(MIN_TILE);
   localparam int NODE_COUNT = ((4 ** (LEVELS + 1)) - 1) / 3;
   localparam int AW = $clog2(NODE_COUNT);
   localparam int LW = $clog2(LEVELS + 1);
   localparam int CW = (LEVELS > 0) ? LEVELS : 1;
   localparam int MW = 2 * CW;

   logic [1:0] node_mem [NODE_COUNT];
   logic [1:0] rdata_ff;

   logic [CMD_W-1:0]   cmd_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic [COORD_W-1:0] x_ff, y_ff;
   logic [MW-1:0]      m_ff, m_in;
   logic [LW-1:0]      wl_ff, wl_in;
   logic [CW-1:0]      wx_ff, wx_in, wy_ff, wy_in;
   logic [1:0]         c_ff, c_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [TILES_W-1:0] tiles_ff, tiles_in;
   logic [AREA_W-1:0]  area_ff, area_in;
   status_type         pend_status_ff;
   logic [COORD_W-1:0] pend_x_ff, pend_y_ff;
   logic [SIZE_W-1:0]  pend_size_ff;
   logic               valid_ff, valid_in;
   logic [STATUS_W-1:0] res_status_ff;
   logic [COORD_W-1:0] res_x_ff, res_y_ff;
   logic [SIZE_W-1:0]  res_size_ff;
   logic [TILES_W-1:0] res_tiles_ff;
   logic [AREA_W-1:0]  res_area_ff;

   logic [SHIFT_W-1:0] sh;
   logic [LW-1:0]      lv;
   logic               size_ok;
   logic [15:0]        gxf, gyf;
   logic [CW-1:0]      ex, ey, tx, ty, cx, cy;
   logic [AREA_W-1:0]  area_step;
   logic [AW-1:0]      a_target, a_walk, a_child, raddr, waddr;

   function automatic logic [AW-1:0] node_addr(input logic [LW-1:0] level,
                                               input logic [CW-1:0] gx,
                                               input logic [CW-1:0] gy);
      logic [AW-1:0] base;
      base = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (i < int'(level)) begin
            base = base | (AW'(1) << (2 * i));
         end
      end
      return base + (AW'(gy) << level) + AW'(gx);
   endfunction

   always_comb begin
      sh = onehot_log2(size_ff);
      lv = LW'(LOG_ATLAS - int'(sh));
      size_ok = (size_ff != '0) && ((size_ff & (size_ff - SIZE_W'(1))) == '0) &&
                (32'(size_ff) >= 32'(MIN_TILE)) && (32'(size_ff) <= 32'(ATLAS_EXTENT));
      gxf = 16'(x_ff) >> sh;
      gyf = 16'(y_ff) >> sh;
      for (int b = 0; b < CW; b++) begin
         ex[b] = m_ff[2 * b];
         ey[b] = m_ff[2 * b + 1];
      end
      if (cmd_ff == CMD_ALLOC) begin
         tx = ex;
         ty = ey;
      end else begin
         tx = gxf[CW-1:0];
         ty = gyf[CW-1:0];
      end
      cx = (wx_ff & ~CW'(1)) | CW'(c_ff[0]);
      cy = (wy_ff & ~CW'(1)) | CW'(c_ff[1]);
      a_target = node_addr(lv, tx, ty);
      a_walk = node_addr(wl_ff, wx_ff, wy_ff);
      a_child = node_addr(wl_ff, cx, cy);
      area_step = AREA_W'(1) << (2 * sh);
   end

   always_comb begin
      case (ctl.rd_sel)
         ADDR_WALK:  raddr = a_walk;
         ADDR_CHILD: raddr = a_child;
         ADDR_CLEAR: raddr = clr_ff;
         default:    raddr = a_target;
      endcase
      case (ctl.wr_sel)
         ADDR_WALK:  waddr = a_walk;
         ADDR_CHILD: waddr = a_child;
         ADDR_CLEAR: waddr = clr_ff;
         default:    waddr = a_target;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         node_mem[waddr] <= ctl.wr_mark;
      end
      if (ctl.rd_en) begin
         rdata_ff <= node_mem[raddr];
      end
   end

   always_comb begin
      m_in = m_ff;
      if (ctl.scan_init) begin
         m_in = '0;
      end else if (ctl.scan_next) begin
         m_in = m_ff + MW'(1);
      end
      wl_in = wl_ff;
      wx_in = wx_ff;
      wy_in = wy_ff;
      if (ctl.walk_init) begin
         wl_in = lv;
         wx_in = tx;
         wy_in = ty;
      end else if (ctl.walk_up) begin
         wl_in = wl_ff - LW'(1);
         wx_in = wx_ff >> 1;
         wy_in = wy_ff >> 1;
      end
      c_in = c_ff;
      if (ctl.child_clr) begin
         c_in = '0;
      end else if (ctl.child_next) begin
         c_in = c_ff + 2'd1;
      end
      clr_in = clr_ff;
      if (ctl.clr_init) begin
         clr_in = '0;
      end else if (ctl.clr_step) begin
         clr_in = clr_ff + AW'(1);
      end
      tiles_in = tiles_ff;
      area_in = area_ff;
      if (ctl.cnt_clr) begin
         tiles_in = '0;
         area_in = '0;
      end else if (ctl.cnt_inc) begin
         tiles_in = tiles_ff + TILES_W'(1);
         area_in = area_ff + area_step;
      end else if (ctl.cnt_dec) begin
         tiles_in = tiles_ff - TILES_W'(1);
         area_in = area_ff - area_step;
      end
      valid_in = valid_ff;
      if (ctl.res_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         tiles_ff <= '0;
         area_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         clr_ff <= clr_in;
         tiles_ff <= tiles_in;
         area_ff <= area_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in;
      wl_ff <= wl_in;
      wx_ff <= wx_in;
      wy_ff <= wy_in;
      c_ff <= c_in;
      if (ctl.latch) begin
         cmd_ff <= req_command;
         size_ff <= req_tile_size;
         x_ff <= req_tile_x;
         y_ff <= req_tile_y;
      end
      if (ctl.pend_set) begin
         pend_status_ff <= ctl.pend_status;
         if (ctl.pend_alloc) begin
            pend_x_ff <= COORD_W'(32'(tx) << sh);
            pend_y_ff <= COORD_W'(32'(ty) << sh);
            pend_size_ff <= size_ff;
         end else begin
            pend_x_ff <= '0;
            pend_y_ff <= '0;
            pend_size_ff <= '0;
         end
      end
      if (ctl.res_load) begin
         res_status_ff <= pend_status_ff;
         res_x_ff <= pend_x_ff;
         res_y_ff <= pend_y_ff;
         res_size_ff <= pend_size_ff;
         res_tiles_ff <= tiles_ff;
         res_area_ff <= area_ff;
      end
   end

   always_comb begin
      stat.cmd = cmd_ff;
      stat.size_ok = size_ok;
      stat.grid_ok = ((32'(x_ff) >> LOG_ATLAS) == 0) && ((32'(y_ff) >> LOG_ATLAS) == 0);
      stat.rd_mark = mark_type'(rdata_ff);
      stat.m_last = 32'(m_ff) == ((32'(1) << (2 * int'(lv))) - 32'(1));
      stat.wl_zero = wl_ff == '0;
      stat.child_last = c_ff == 2'd3;
      stat.clr_last = clr_ff == AW'(NODE_COUNT - 1);
      stat.out_free = !valid_ff || rsp_tready;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_status = res_status_ff;
   assign rsp_out_x = res_x_ff;
   assign rsp_out_y = res_y_ff;
   assign rsp_out_size = res_size_ff;
   assign rsp_live_tiles = res_tiles_ff;
   assign rsp_live_area = res_area_ff;

endmodule

FILE: hdl/quadtree_tile_allocator.sv
// Quadtree tile allocator: one request in, one response out per transfer. Allocate takes
// the first free tile of the requested size in Morton order and answers with its texel
// origin; free releases a tile and merges empty quadrants upward; clear empties the tree.
// Node marks sit in a single-port-read, single-port-write memory of (4^(L+1)-1)/3 entries,
// L = log2(ATLAS_EXTENT/MIN_TILE), and every mark read is registered (address, then data).
// Every request is taken in IDLE, decoded in DECODE and answered by loading the response
// in RESP. Allocate scans nodes of the requested level, checks each empty one's ancestors
// for an allocated tile, then marks it and turns empty ancestors into split nodes; free
// checks that the tile is allocated, empties it and, level by level, empties a split parent
// whose four children are all empty; clear empties every node in turn (341 nodes by default).
// The same clearing pass runs after reset, during which no request is taken. A response held
// back by the receiver stalls the next one until it goes.
module quadtree_tile_allocator
   import qta_pkg::*;
#(
   parameter int ATLAS_EXTENT = 4096,
   parameter int MIN_TILE = 256
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // tile_size, tile_x, tile_y
   input  logic [1:0]  req_tuser,  // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // out_x, out_y, out_size, live_tiles, live_area
   output logic [1:0]  rsp_tuser   // status
);

   ctl_cmd_type         ctl;
   dp_stat_type         stat;
   logic [STATUS_W-1:0] status;
   logic [COORD_W-1:0]  out_x, out_y;
   logic [SIZE_W-1:0]   out_size;
   logic [TILES_W-1:0]  live_tiles;
   logic [AREA_W-1:0]   live_area;

   qta_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .ctl        (ctl)
   );

   qta_datapath #(
      .ATLAS_EXTENT (ATLAS_EXTENT),
      .MIN_TILE     (MIN_TILE)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_command    (req_tuser),
      .req_tile_size  (req_tdata[12:0]),
      .req_tile_x     (req_tdata[24:13]),
      .req_tile_y     (req_tdata[36:25]),
      .ctl            (ctl),
      .stat           (stat),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_status     (status),
      .rsp_out_x      (out_x),
      .rsp_out_y      (out_y),
      .rsp_out_size   (out_size),
      .rsp_live_tiles (live_tiles),
      .rsp_live_area  (live_area)
   );

   assign rsp_tuser = status;
   assign rsp_tdata = {1'b0, live_area, live_tiles, out_size, out_y, out_x};

endmodule

FILE: tb/sv/quadtree_tile_allocator_test.sv
module quadtree_tile_allocator_test;
   import qta_pkg::*;

   localparam int NODES = 341;
   localparam int RANDOM_ITEMS = 1100;

   typedef struct {
      status_type  status;
      logic [11:0] out_x;
      logic [11:0] out_y;
      logic [12:0] out_size;
      logic [8:0]  live_tiles;
      logic [24:0] live_area;
   } tile_reply_type;

   typedef struct {
      int x;
      int y;
      int size;
   } live_tile_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   mark_type       node_mark [NODES];
   logic [8:0]     tile_count;
   logic [24:0]    area_total;
   tile_reply_type reply_q[$];
   live_tile_type  live_tiles[$];
   int             send_idle_pct;
   int             recv_stall_pct;
   int             failures;

   quadtree_tile_allocator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic int node_index(int lvl, int gx, int gy);
      return ((1 << (2 * lvl)) - 1) / 3 + gy * (1 << lvl) + gx;
   endfunction

   function automatic bit size_valid(int s);
      return s >= 256 && s <= 4096 && (s & (s - 1)) == 0;
   endfunction

   function automatic int size_level(int s);
      int lvl;
      int ext;
      lvl = 0;
      ext = 4096;
      while (ext > s) begin
         ext = ext >> 1;
         lvl++;
      end
      return lvl;
   endfunction

   function automatic void clear_tree();
      foreach (node_mark[i]) node_mark[i] = MARK_EMPTY;
      tile_count = '0;
      area_total = '0;
      live_tiles.delete();
   endfunction

   function automatic void allocate_tile(int s, ref tile_reply_type r);
      int lvl;
      int gx;
      int gy;
      int ax;
      int ay;
      bit found;
      bit blocked;
      live_tile_type t;
      found = 0;
      if (!size_valid(s)) begin
         r.status = STATUS_INVALID;
         return;
      end
      lvl = size_level(s);
      for (int m = 0; m < (1 << (2 * lvl)) && !found; m++) begin
         gx = 0;
         gy = 0;
         for (int b = 0; b < 8; b++) begin
            gx |= ((m >> (2 * b)) & 1) << b;
            gy |= ((m >> (2 * b + 1)) & 1) << b;
         end
         if (node_mark[node_index(lvl, gx, gy)] == MARK_EMPTY) begin
            blocked = 0;
            for (int l = lvl - 1; l >= 0; l--)
               if (node_mark[node_index(l, gx >> (lvl - l), gy >> (lvl - l))] == MARK_ALLOC)
                  blocked = 1;
            if (!blocked) begin
               found = 1;
               node_mark[node_index(lvl, gx, gy)] = MARK_ALLOC;
               for (int l = lvl - 1; l >= 0; l--) begin
                  ax = gx >> (lvl - l);
                  ay = gy >> (lvl - l);
                  if (node_mark[node_index(l, ax, ay)] == MARK_EMPTY)
                     node_mark[node_index(l, ax, ay)] = MARK_SPLIT;
               end
               tile_count = tile_count + 9'd1;
               area_total = area_total + 25'(s * s);
               r.out_x = 12'(gx * s);
               r.out_y = 12'(gy * s);
               r.out_size = 13'(s);
               t.x = gx * s;
               t.y = gy * s;
               t.size = s;
               live_tiles.push_back(t);
            end
         end
      end
      if (!found) r.status = STATUS_NO_FREE;
   endfunction

   function automatic void free_tile(int s, int x, int y, ref tile_reply_type r);
      int lvl;
      int gx;
      int gy;
      bit busy;
      bit stop;
      if (!size_valid(s)) begin
         r.status = STATUS_INVALID;
         return;
      end
      lvl = size_level(s);
      gx = x / s;
      gy = y / s;
      if (gx >= (1 << lvl) || gy >= (1 << lvl) ||
          node_mark[node_index(lvl, gx, gy)] != MARK_ALLOC) begin
         r.status = STATUS_INVALID;
         return;
      end
      node_mark[node_index(lvl, gx, gy)] = MARK_EMPTY;
      tile_count = tile_count - 9'd1;
      area_total = area_total - 25'(s * s);
      foreach (live_tiles[i])
         if (live_tiles[i].size == s && live_tiles[i].x == gx * s && live_tiles[i].y == gy * s) begin
            live_tiles.delete(i);
            break;
         end
      // merge empty quadrants upward
      stop = 0;
      while (lvl > 0 && !stop) begin
         busy = 0;
         for (int cy = 0; cy < 2; cy++)
            for (int cx = 0; cx < 2; cx++)
               if (node_mark[node_index(lvl, (gx & ~1) + cx, (gy & ~1) + cy)] != MARK_EMPTY)
                  busy = 1;
         lvl--;
         gx = gx >> 1;
         gy = gy >> 1;
         if (busy || node_mark[node_index(lvl, gx, gy)] != MARK_SPLIT) stop = 1;
         else node_mark[node_index(lvl, gx, gy)] = MARK_EMPTY;
      end
   endfunction

   function automatic void predict_reply(logic [1:0] c, int s, int x, int y);
      tile_reply_type r;
      r.status = STATUS_DONE;
      r.out_x = '0;
      r.out_y = '0;
      r.out_size = '0;
      case (c)
         CMD_ALLOC: allocate_tile(s, r);
         CMD_FREE:  free_tile(s, x, y, r);
         CMD_CLEAR: clear_tree();
         default:   r.status = STATUS_INVALID;
      endcase
      r.live_tiles = tile_count;
      r.live_area = area_total;
      reply_q.push_back(r);
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_request(logic [1:0] c, logic [12:0] s, logic [11:0] x, logic [11:0] y);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, y, x, s};
      req_tuser <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_reply(c, int'(s), int'(x), int'(y));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (reply_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   always @(posedge clock) begin
      tile_reply_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (reply_q.size() == 0) begin
            $error("response transfer with nothing outstanding");
            failures++;
         end else begin
            e = reply_q.pop_front();
            if (rsp_tuser !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_tuser);
               failures++;
            end
            if (rsp_tdata[11:0] !== e.out_x) begin
               $error("out_x expected %0d actual %0d", e.out_x, rsp_tdata[11:0]);
               failures++;
            end
            if (rsp_tdata[23:12] !== e.out_y) begin
               $error("out_y expected %0d actual %0d", e.out_y, rsp_tdata[23:12]);
               failures++;
            end
            if (rsp_tdata[36:24] !== e.out_size) begin
               $error("out_size expected %0d actual %0d", e.out_size, rsp_tdata[36:24]);
               failures++;
            end
            if (rsp_tdata[45:37] !== e.live_tiles) begin
               $error("live_tiles expected %0d actual %0d", e.live_tiles, rsp_tdata[45:37]);
               failures++;
            end
            if (rsp_tdata[70:46] !== e.live_area) begin
               $error("live_area expected %0d actual %0d", e.live_area, rsp_tdata[70:46]);
               failures++;
            end
         end
      end
   end

   task automatic test_directed();
      send_request(CMD_ALLOC, 13'd4096, 12'd0, 12'd0);
      send_request(CMD_ALLOC, 13'd256, 12'd0, 12'd0);
      send_request(CMD_FREE, 13'd4096, 12'd4095, 12'd4095);
      send_request(CMD_FREE, 13'd4096, 12'd0, 12'd0);
      for (int s = 256; s <= 4096; s = s * 2)
         send_request(CMD_ALLOC, 13'(s), 12'd0, 12'd0);
      send_request(CMD_ALLOC, 13'd0, 12'd0, 12'd0);
      send_request(CMD_ALLOC, 13'd255, 12'd0, 12'd0);
      send_request(CMD_ALLOC, 13'd384, 12'd0, 12'd0);
      send_request(CMD_ALLOC, 13'd8191, 12'd0, 12'd0);
      send_request(CMD_ALLOC, 13'd8192, 12'd0, 12'd0);
      send_request(CMD_FREE, 13'd128, 12'd0, 12'd0);
      send_request(CMD_FREE, 13'd256, 12'd4095, 12'd4095);
      send_request(CMD_FREE, 13'd2048, 12'd2047, 12'd2047);
      send_request(CMD_FREE, 13'd256, 12'd300, 12'd700);
      send_request(2'd3, 13'd8191, 12'd4095, 12'd4095);
      send_request(CMD_CLEAR, 13'd0, 12'd0, 12'd0);
      send_request(CMD_FREE, 13'd256, 12'd0, 12'd0);
   endtask

   task automatic test_fill();
      send_idle_pct = 20;
      recv_stall_pct = 20;
      for (int i = 0; i < 257; i++) send_request(CMD_ALLOC, 13'd256, 12'd0, 12'd0);
      send_request(CMD_ALLOC, 13'd1024, 12'd0, 12'd0);
      for (int i = 0; i < 40; i++) begin
         live_tile_type t;
         t = live_tiles[$urandom_range(live_tiles.size() - 1)];
         send_request(CMD_FREE, 13'(t.size), 12'(t.x), 12'(t.y));
      end
      send_request(CMD_CLEAR, 13'd0, 12'd0, 12'd0);
   endtask

   task automatic send_random_item();
      int pick;
      int s;
      live_tile_type t;
      pick = $urandom_range(99);
      if (pick < 45) begin
         s = ($urandom_range(9) < 7) ? 256 << $urandom_range(1) : 256 << $urandom_range(4);
         send_request(CMD_ALLOC, 13'(s), 12'($urandom), 12'($urandom));
      end else if (pick < 80 && live_tiles.size() != 0) begin
         t = live_tiles[$urandom_range(live_tiles.size() - 1)];
         send_request(CMD_FREE, 13'(t.size), 12'(t.x + $urandom_range(t.size - 1)),
                      12'(t.y + $urandom_range(t.size - 1)));
      end else if (pick < 86) begin
         send_request(CMD_FREE, 13'(256 << $urandom_range(4)), 12'($urandom), 12'($urandom));
      end else if (pick < 91) begin
         send_request(2'($urandom_range(1)), 13'($urandom), 12'($urandom), 12'($urandom));
      end else if (pick < 94) begin
         send_request(CMD_CLEAR, 13'($urandom), 12'($urandom), 12'($urandom));
      end else if (pick < 96) begin
         send_request(2'd3, 13'($urandom), 12'($urandom), 12'($urandom));
      end else begin
         send_request(CMD_ALLOC, 13'd256, 12'd0, 12'd0);
      end
   endtask

   task automatic test_random();
      int send_mode [4] = '{0, 85, 0, 38};
      int recv_mode [4] = '{0, 0, 85, 38};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_mode[p];
         recv_stall_pct = recv_mode[p];
         for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
            send_random_item();
            if (p == 1 && i == RANDOM_ITEMS / 8) wait_drained();
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      failures = 0;
      clear_tree();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_fill();
      test_random();
      req_tvalid <= 1'b0;
      recv_stall_pct = 0;
      while (reply_q.size() != 0) @(negedge clock);
      repeat (5000) @(negedge clock);
      if (failures == 0 && reply_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #400000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: sim.f
hdl/qta_pkg.sv
hdl/qta_ctrl.sv
hdl/qta_datapath.sv
hdl/quadtree_tile_allocator.sv
tb/sv/quadtree_tile_allocator_test.sv
